[sv/assert_macros.svh]
// Assertion helpers for the allocator core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/ffpa_pkg.sv]
package ffpa_pkg;

    localparam int KIND_W   = 2;
    localparam int BYTES_W  = 12;
    localparam int ADDR_W   = 10;
    localparam int STATUS_W = 2;
    localparam int UNITS_W  = 7;

    // Width of the divider; holds a byte count rounded up and any unit index.
    localparam int DIV_W    = 13;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OOM      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTES_W-1:0] request_bytes;
        logic [ADDR_W-1:0]  block_address;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   granted_address;
        logic [UNITS_W-1:0]  granted_units;
    } rsp_t;

endpackage

[sv/ffpa_ram.sv]
module ffpa_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/ffpa_div.sv]
module ffpa_div #(
    parameter int DIVISOR = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ffpa_pkg::DIV_W-1:0] dividend,
    output logic                       done,
    output logic [ffpa_pkg::DIV_W-1:0] quotient
);

    localparam int DW  = ffpa_pkg::DIV_W;
    localparam int SH  = DW + $clog2(DIVISOR);
    localparam int PRW = SH + DW;
    // Reciprocal of the divisor scaled by 2^SH and rounded up. With this scale
    // the product gives the exact quotient for every DW-bit dividend.
    localparam longint RECIP = ((longint'(1) << SH) + longint'(DIVISOR) - 1)
                               / longint'(DIVISOR);

    logic          done_reg;
    logic [DW-1:0] quo_reg, quo_next;
    logic [PRW-1:0] prod;

    assign prod     = PRW'(dividend) * PRW'(RECIP);
    assign quo_next = prod[SH +: DW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= start;
            if (start)
            begin
                quo_reg <= quo_next;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[sv/first_fit_pool_allocator_core.sv]
// First-fit pool allocator. Requests arrive on the req channel (req_valid,
// req_ready, req) and each produces exactly one item on the rsp channel
// (rsp_valid, rsp_ready, rsp). An allocate turns bytes into units, tries the
// pools in order and splits or unlinks the first free block that fits. A free
// reinserts the block in address order and merges it with each neighbor it adjoins.
// A clear reformats every pool.
// The block works on one request at a time and req_ready is low meanwhile.
// An allocate turns bytes into units with a constant reciprocal multiply, checks
// the free count of each pool in order, reads the free-list nodes of a pool that
// may fit from the header memory, leaves a pool whose list had no fit, then writes
// the headers and produces the result. A free finds its pool by stepping through
// the pool bases, reads the block header, walks the list nodes, then checks,
// writes and produces the result. A clear writes the head block of each pool in
// turn. The header memory serves one read per cycle.
// After reset the block sweeps the whole header memory, POOL_COUNT * POOL_UNITS
// entries (768 by default), one entry per cycle, and keeps req_ready low
// meanwhile. A finished result waits in an output register; the next request
// is accepted while it waits, but a second result is not produced until the
// receiver has taken the first, so a stalled receiver stalls the block.
`include "assert_macros.svh"

module first_fit_pool_allocator_core #(
    parameter int POOL_COUNT = 12,
    parameter int POOL_UNITS = 64,
    parameter int UNIT_BYTES = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ffpa_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ffpa_pkg::rsp_t rsp
);

    localparam int TOTAL = POOL_COUNT * POOL_UNITS;
    localparam int MAW   = $clog2(TOTAL);
    localparam int OW    = $clog2(POOL_UNITS + 1);
    localparam int EW    = 2 * OW;
    localparam int PW    = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
    localparam int PCW   = $clog2(POOL_COUNT + 1);
    localparam int DW    = ffpa_pkg::DIV_W;
    localparam int NUW   = DW + 1;

    // A link equal to the pool size marks the end of a free list.
    localparam logic [OW-1:0] LIST_END = OW'(POOL_UNITS);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_ADIV, S_PSCAN, S_WREQ, S_WRD, S_W2,
        S_FDIV, S_FSZR, S_FSZ, S_FREQ, S_FRD, S_FCHK, S_FMT, S_DONE
    } state_t;

    state_t               state_reg, state_next;
    ffpa_pkg::req_t       req_reg, req_next;
    ffpa_pkg::rsp_t       res_reg, res_next;
    ffpa_pkg::rsp_t       rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [PCW-1:0]       pidx_reg, pidx_next;
    logic [MAW-1:0]       base_reg, base_next;
    logic [OW-1:0]        pos_reg, pos_next;
    logic [OW-1:0]        prev_reg, prev_next;
    logic [OW-1:0]        prev_size_reg, prev_size_next;
    logic [OW-1:0]        cur_size_reg, cur_size_next;
    logic [OW-1:0]        cur_next_reg, cur_next_next;
    logic [OW-1:0]        guard_reg, guard_next;
    logic [NUW-1:0]       nu_reg, nu_next;
    logic [OW-1:0]        off_reg, off_next;
    logic [OW-1:0]        sz_reg, sz_next;
    logic [OW-1:0]        grant_reg, grant_next;
    logic [MAW-1:0]       g_reg, g_next;
    logic                 w2_en_reg, w2_en_next;
    logic [MAW-1:0]       w2_addr_reg, w2_addr_next;
    logic [EW-1:0]        w2_data_reg, w2_data_next;
    logic [MAW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [OW-1:0]        clr_off_reg, clr_off_next;
    logic [OW-1:0]        head_reg [POOL_COUNT];
    logic [OW-1:0]        free_reg [POOL_COUNT];

    logic                 head_we, free_we, fmt_all;
    logic [OW-1:0]        head_wdata, free_wdata;
    logic                 mem_we;
    logic [MAW-1:0]       mem_waddr, mem_raddr;
    logic [EW-1:0]        mem_wdata, mem_rdata;
    logic [OW-1:0]        rd_size, rd_next;
    logic                 div_start, div_done;
    logic [DW-1:0]        div_dividend, div_quo;
    logic [PW-1:0]        pi;
    logic [ffpa_pkg::BYTES_W-1:0] bytes1;
    logic [ffpa_pkg::ADDR_W-1:0]  a_m1;
    logic                 addr_bad;
    logic                 prev_end, merge_hi, merge_lo, free_reject;
    logic [OW:0]          prev_top, off_top;
    logic [OW-1:0]        gsize, gnext, split_size;
    logic [MAW:0]         payload;
    logic                 g_above_pool;

    assign pi       = pidx_reg[PW-1:0];
    assign rd_size  = mem_rdata[OW-1:0];
    assign rd_next  = mem_rdata[EW-1:OW];
    assign bytes1   = (req.request_bytes == '0) ? ffpa_pkg::BYTES_W'(1) : req.request_bytes;
    assign a_m1     = req.block_address - 1'b1;
    assign addr_bad = (req.block_address == '0) || (32'(a_m1) >= 32'(TOTAL));

    // The freed unit lies above the pool that base_reg points at.
    assign g_above_pool = (MAW+1)'(g_reg) >= (MAW+1)'(base_reg) + (MAW+1)'(POOL_UNITS);

    // Checks and merge decisions for a free, taken once the walk has stopped.
    assign prev_end    = prev_reg == LIST_END;
    assign prev_top    = (OW+1)'(prev_reg) + (OW+1)'(prev_size_reg);
    assign off_top     = (OW+1)'(off_reg) + (OW+1)'(sz_reg);
    assign free_reject = (pos_reg == off_reg)
                      || (!prev_end && prev_top > (OW+1)'(off_reg))
                      || (off_top > (OW+1)'(pos_reg));
    assign merge_hi    = (pos_reg != LIST_END) && (off_top == (OW+1)'(pos_reg));
    assign merge_lo    = !prev_end && (prev_top == (OW+1)'(off_reg));
    assign gsize       = merge_hi ? sz_reg + cur_size_reg : sz_reg;
    assign gnext       = merge_hi ? cur_next_reg : pos_reg;
    assign split_size  = rd_size - OW'(nu_reg);
    assign payload     = (MAW+1)'(base_reg) + (MAW+1)'(grant_reg) + 1'b1;

    ffpa_div #(
        .DIVISOR (UNIT_BYTES)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quo)
    );

    ffpa_ram #(
        .WIDTH (EW),
        .DEPTH (TOTAL)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        pidx_next      = pidx_reg;
        base_next      = base_reg;
        pos_next       = pos_reg;
        prev_next      = prev_reg;
        prev_size_next = prev_size_reg;
        cur_size_next  = cur_size_reg;
        cur_next_next  = cur_next_reg;
        guard_next     = guard_reg;
        nu_next        = nu_reg;
        off_next       = off_reg;
        sz_next        = sz_reg;
        grant_next     = grant_reg;
        g_next         = g_reg;
        w2_en_next     = w2_en_reg;
        w2_addr_next   = w2_addr_reg;
        w2_data_next   = w2_data_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_off_next   = clr_off_reg;
        head_we        = 1'b0;
        head_wdata     = '0;
        free_we        = 1'b0;
        free_wdata     = '0;
        fmt_all        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_raddr      = '0;
        div_start      = 1'b0;
        div_dividend   = '0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR:
            begin
                // Every base unit holds one whole-pool free block; the rest reads as zero.
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = (clr_off_reg == '0) ? {LIST_END, OW'(POOL_UNITS)} : '0;
                clr_off_next = (clr_off_reg == OW'(POOL_UNITS - 1)) ? '0 : clr_off_reg + 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == MAW'(TOTAL - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next  = req;
                    pidx_next = '0;
                    base_next = '0;
                    res_next  = '{ffpa_pkg::STATUS_DONE, '0, '0};
                    case (req.kind)
                        ffpa_pkg::KIND_ALLOC:
                        begin
                            div_start    = 1'b1;
                            div_dividend = DW'(bytes1) + DW'(UNIT_BYTES - 1);
                            state_next   = S_ADIV;
                        end
                        ffpa_pkg::KIND_FREE:
                        begin
                            if (addr_bad)
                            begin
                                res_next.status = ffpa_pkg::STATUS_BAD_ADDR;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                g_next     = MAW'(a_m1);
                                state_next = S_FDIV;
                            end
                        end
                        ffpa_pkg::KIND_CLEAR:
                        begin
                            fmt_all    = 1'b1;
                            state_next = S_FMT;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ADIV:
            begin
                if (div_done)
                begin
                    nu_next    = NUW'(div_quo) + 1'b1;
                    state_next = S_PSCAN;
                end
            end
            S_PSCAN:
            begin
                if (pidx_reg == PCW'(POOL_COUNT))
                begin
                    res_next.status = ffpa_pkg::STATUS_OOM;
                    state_next      = S_DONE;
                end
                else if (NUW'(free_reg[pi]) >= nu_reg)
                begin
                    pos_next   = head_reg[pi];
                    prev_next  = LIST_END;
                    guard_next = '0;
                    state_next = S_WREQ;
                end
                else
                begin
                    pidx_next = pidx_reg + 1'b1;
                    base_next = base_reg + MAW'(POOL_UNITS);
                end
            end
            S_WREQ:
            begin
                if (pos_reg != LIST_END && guard_reg < OW'(POOL_UNITS))
                begin
                    mem_raddr  = base_reg + MAW'(pos_reg);
                    state_next = S_WRD;
                end
                else
                begin
                    // This pool has no block large enough; go on to the next one.
                    pidx_next  = pidx_reg + 1'b1;
                    base_next  = base_reg + MAW'(POOL_UNITS);
                    state_next = S_PSCAN;
                end
            end
            S_WRD:
            begin
                if (NUW'(rd_size) >= nu_reg)
                begin
                    w2_en_next = 1'b1;
                    if (NUW'(rd_size) == nu_reg)
                    begin
                        // Exact fit: unlink the block.
                        if (prev_reg == LIST_END)
                        begin
                            head_we    = 1'b1;
                            head_wdata = rd_next;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = base_reg + MAW'(prev_reg);
                            mem_wdata = {rd_next, prev_size_reg};
                        end
                        grant_next   = pos_reg;
                        w2_addr_next = base_reg + MAW'(pos_reg);
                    end
                    else
                    begin
                        // Split: the block shrinks and its tail is given out.
                        mem_we       = 1'b1;
                        mem_waddr    = base_reg + MAW'(pos_reg);
                        mem_wdata    = {rd_next, split_size};
                        grant_next   = pos_reg + split_size;
                        w2_addr_next = base_reg + MAW'(pos_reg + split_size);
                    end
                    w2_data_next = {LIST_END, OW'(nu_reg)};
                    state_next   = S_W2;
                end
                else
                begin
                    prev_next      = pos_reg;
                    prev_size_next = rd_size;
                    pos_next       = rd_next;
                    guard_next     = guard_reg + 1'b1;
                    state_next     = S_WREQ;
                end
            end
            S_W2:
            begin
                mem_we    = w2_en_reg;
                mem_waddr = w2_addr_reg;
                mem_wdata = w2_data_reg;
                free_we   = 1'b1;
                if (req_reg.kind == ffpa_pkg::KIND_ALLOC)
                begin
                    free_wdata               = free_reg[pi] - OW'(nu_reg);
                    res_next.granted_address = ffpa_pkg::ADDR_W'(payload);
                    res_next.granted_units   = ffpa_pkg::UNITS_W'(nu_reg);
                end
                else
                begin
                    free_wdata             = free_reg[pi] + sz_reg;
                    res_next.granted_units = ffpa_pkg::UNITS_W'(sz_reg);
                end
                state_next = S_DONE;
            end
            S_FDIV:
            begin
                // Step through the pool bases until the freed unit falls inside one.
                if (g_above_pool)
                begin
                    pidx_next = pidx_reg + 1'b1;
                    base_next = base_reg + MAW'(POOL_UNITS);
                end
                else
                begin
                    off_next   = OW'(g_reg - base_reg);
                    state_next = S_FSZR;
                end
            end
            S_FSZR:
            begin
                mem_raddr  = g_reg;
                state_next = S_FSZ;
            end
            S_FSZ:
            begin
                if (rd_size == '0)
                begin
                    res_next.status = ffpa_pkg::STATUS_BAD_ADDR;
                    state_next      = S_DONE;
                end
                else
                begin
                    sz_next    = rd_size;
                    pos_next   = head_reg[pi];
                    prev_next  = LIST_END;
                    guard_next = '0;
                    state_next = S_FREQ;
                end
            end
            S_FREQ:
            begin
                // The node at or above the freed offset is read too: its size and link feed the merge.
                if (pos_reg != LIST_END && (pos_reg >= off_reg || guard_reg < OW'(POOL_UNITS)))
                begin
                    mem_raddr  = base_reg + MAW'(pos_reg);
                    state_next = S_FRD;
                end
                else
                begin
                    state_next = S_FCHK;
                end
            end
            S_FRD:
            begin
                cur_size_next = rd_size;
                cur_next_next = rd_next;
                if (pos_reg < off_reg)
                begin
                    prev_next      = pos_reg;
                    prev_size_next = rd_size;
                    pos_next       = rd_next;
                    guard_next     = guard_reg + 1'b1;
                    state_next     = S_FREQ;
                end
                else
                begin
                    state_next = S_FCHK;
                end
            end
            S_FCHK:
            begin
                if (free_reject)
                begin
                    res_next.status = ffpa_pkg::STATUS_BAD_ADDR;
                    state_next      = S_DONE;
                end
                else
                begin
                    mem_we       = 1'b1;
                    mem_waddr    = g_reg;
                    mem_wdata    = {gnext, gsize};
                    w2_en_next   = !prev_end;
                    w2_addr_next = base_reg + MAW'(prev_reg);
                    if (merge_lo)
                    begin
                        w2_data_next = {gnext, prev_size_reg + gsize};
                    end
                    else
                    begin
                        w2_data_next = {off_reg, prev_size_reg};
                    end
                    if (prev_end)
                    begin
                        head_we    = 1'b1;
                        head_wdata = off_reg;
                    end
                    state_next = S_W2;
                end
            end
            S_FMT:
            begin
                mem_we    = 1'b1;
                mem_waddr = base_reg;
                mem_wdata = {LIST_END, OW'(POOL_UNITS)};
                pidx_next = pidx_reg + 1'b1;
                base_next = base_reg + MAW'(POOL_UNITS);
                if (pidx_reg == PCW'(POOL_COUNT - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            req_reg       <= '0;
            res_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            pidx_reg      <= '0;
            base_reg      <= '0;
            pos_reg       <= '0;
            prev_reg      <= '0;
            prev_size_reg <= '0;
            cur_size_reg  <= '0;
            cur_next_reg  <= '0;
            guard_reg     <= '0;
            nu_reg        <= '0;
            off_reg       <= '0;
            sz_reg        <= '0;
            grant_reg     <= '0;
            g_reg         <= '0;
            w2_en_reg     <= 1'b0;
            w2_addr_reg   <= '0;
            w2_data_reg   <= '0;
            clr_cnt_reg   <= '0;
            clr_off_reg   <= '0;
            for (int i = 0; i < POOL_COUNT; i++)
            begin
                head_reg[i] <= '0;
                free_reg[i] <= OW'(POOL_UNITS);
            end
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            res_reg       <= res_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
            pidx_reg      <= pidx_next;
            base_reg      <= base_next;
            pos_reg       <= pos_next;
            prev_reg      <= prev_next;
            prev_size_reg <= prev_size_next;
            cur_size_reg  <= cur_size_next;
            cur_next_reg  <= cur_next_next;
            guard_reg     <= guard_next;
            nu_reg        <= nu_next;
            off_reg       <= off_next;
            sz_reg        <= sz_next;
            grant_reg     <= grant_next;
            g_reg         <= g_next;
            w2_en_reg     <= w2_en_next;
            w2_addr_reg   <= w2_addr_next;
            w2_data_reg   <= w2_data_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_off_reg   <= clr_off_next;
            if (fmt_all)
            begin
                for (int i = 0; i < POOL_COUNT; i++)
                begin
                    head_reg[i] <= '0;
                    free_reg[i] <= OW'(POOL_UNITS);
                end
            end
            else
            begin
                if (head_we)
                begin
                    head_reg[pi] <= head_wdata;
                end
                if (free_we)
                begin
                    free_reg[pi] <= free_wdata;
                end
            end
        end
    end

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_valid && req_ready, !req_ready)
    `ASSERT_IMP(a_free_count_bounded, clk, rst_n, free_we, free_wdata <= OW'(POOL_UNITS))
    `ASSERT_IMP(a_write_in_store, clk, rst_n, mem_we, 32'(mem_waddr) < 32'(TOTAL))
    `ASSERT_IMP(a_fail_fields_zero, clk, rst_n,
        rsp_valid && rsp.status != ffpa_pkg::STATUS_DONE,
        rsp.granted_address == '0 && rsp.granted_units == '0)

endmodule

[dv/first_fit_pool_allocator_core_test.sv]
module first_fit_pool_allocator_core_test;

    // Geometry of the block as instantiated with its default parameters.
    localparam int NUM_POOLS   = 12;
    localparam int UNITS_EACH  = 64;
    localparam int BYTES_UNIT  = 16;
    localparam int STORE_UNITS = NUM_POOLS * UNITS_EACH;
    localparam int WATCHDOG    = 20000;
    localparam int RANDOM_ITEMS = 500;

    // The one kind that the block ignores.
    localparam logic [ffpa_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    ffpa_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    ffpa_pkg::rsp_t rsp;

    first_fit_pool_allocator_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Shadow copy of the allocator state. Links are pool-relative offsets and
    // UNITS_EACH marks the end of a list.
    int unsigned shadow_next [STORE_UNITS];
    int unsigned shadow_size [STORE_UNITS];
    int unsigned shadow_head [NUM_POOLS];
    int unsigned shadow_free [NUM_POOLS];

    // Results still owed by the block, oldest first.
    ffpa_pkg::rsp_t pending_rsp[$];
    // Payload addresses of blocks that the predictor believes are allocated.
    int unsigned live_blocks[$];

    int mismatches;
    int idle_cycles;

    function automatic void format_pools();
        for (int p = 0; p < NUM_POOLS; p++)
        begin
            shadow_size[p * UNITS_EACH] = UNITS_EACH;
            shadow_next[p * UNITS_EACH] = UNITS_EACH;
            shadow_head[p] = 0;
            shadow_free[p] = UNITS_EACH;
        end
    endfunction

    function automatic bit carve_block(int unsigned p, int unsigned nu,
                                       output int unsigned payload);
        int unsigned base;
        int unsigned prev;
        int unsigned pos;
        int unsigned grant;
        int unsigned steps;
        base = p * UNITS_EACH;
        prev = UNITS_EACH;
        pos = shadow_head[p];
        steps = 0;
        payload = 0;
        while (pos < UNITS_EACH && steps < UNITS_EACH)
        begin
            if (shadow_size[base + pos] >= nu)
            begin
                if (shadow_size[base + pos] == nu)
                begin
                    // Exact fit: unlink the whole block.
                    if (prev == UNITS_EACH)
                        shadow_head[p] = shadow_next[base + pos];
                    else
                        shadow_next[base + prev] = shadow_next[base + pos];
                    grant = pos;
                end
                else
                begin
                    // Larger block: shrink it and hand out its tail.
                    shadow_size[base + pos] -= nu;
                    grant = pos + shadow_size[base + pos];
                    shadow_size[base + grant] = nu;
                end
                shadow_next[base + grant] = UNITS_EACH;
                shadow_free[p] -= nu;
                payload = base + grant + 1;
                return 1'b1;
            end
            prev = pos;
            pos = shadow_next[base + pos];
            steps++;
        end
        return 1'b0;
    endfunction

    function automatic bit return_block(int unsigned g, output int unsigned units);
        int unsigned p;
        int unsigned off;
        int unsigned base;
        int unsigned sz;
        int unsigned prev;
        int unsigned cur;
        int unsigned steps;
        p = g / UNITS_EACH;
        off = g % UNITS_EACH;
        base = p * UNITS_EACH;
        sz = shadow_size[g];
        prev = UNITS_EACH;
        cur = shadow_head[p];
        steps = 0;
        units = 0;
        if (sz == 0)
            return 1'b0;
        while (cur < UNITS_EACH && cur < off && steps < UNITS_EACH)
        begin
            prev = cur;
            cur = shadow_next[base + cur];
            steps++;
        end
        // Reject a block that is already free, overlaps its lower neighbor,
        // or runs past its upper neighbor or the pool end.
        if (cur == off)
            return 1'b0;
        if (prev != UNITS_EACH && prev + shadow_size[base + prev] > off)
            return 1'b0;
        if (off + sz > cur)
            return 1'b0;
        if (cur < UNITS_EACH && off + sz == cur)
        begin
            shadow_size[g] = sz + shadow_size[base + cur];
            shadow_next[g] = shadow_next[base + cur];
        end
        else
            shadow_next[g] = cur;
        if (prev != UNITS_EACH && prev + shadow_size[base + prev] == off)
        begin
            shadow_size[base + prev] += shadow_size[g];
            shadow_next[base + prev] = shadow_next[g];
        end
        else if (prev != UNITS_EACH)
            shadow_next[base + prev] = off;
        else
            shadow_head[p] = off;
        shadow_free[p] += sz;
        units = sz;
        return 1'b1;
    endfunction

    // Computes the result of one request and advances the shadow state.
    function automatic ffpa_pkg::rsp_t predict_allocator(ffpa_pkg::req_t item);
        ffpa_pkg::rsp_t r;
        int unsigned bytes;
        int unsigned nu;
        int unsigned payload;
        int unsigned units;
        int unsigned addr;
        bit ok;
        r = '0;
        r.status = ffpa_pkg::STATUS_DONE;
        addr = 32'(item.block_address);
        if (item.kind == ffpa_pkg::KIND_ALLOC)
        begin
            bytes = 32'(item.request_bytes);
            if (bytes == 0)
                bytes = 1;
            nu = (bytes + BYTES_UNIT - 1) / BYTES_UNIT + 1;
            ok = 1'b0;
            for (int p = 0; p < NUM_POOLS && !ok; p++)
                if (shadow_free[p] >= nu)
                    ok = carve_block(p, nu, payload);
            if (ok)
            begin
                r.granted_address = payload[ffpa_pkg::ADDR_W-1:0];
                r.granted_units = nu[ffpa_pkg::UNITS_W-1:0];
                live_blocks.push_back(payload);
            end
            else
                r.status = ffpa_pkg::STATUS_OOM;
        end
        else if (item.kind == ffpa_pkg::KIND_FREE)
        begin
            if (addr == 0 || addr > STORE_UNITS || !return_block(addr - 1, units))
                r.status = ffpa_pkg::STATUS_BAD_ADDR;
            else
            begin
                r.granted_units = units[ffpa_pkg::UNITS_W-1:0];
                foreach (live_blocks[i])
                    if (live_blocks[i] == addr)
                    begin
                        live_blocks.delete(i);
                        break;
                    end
            end
        end
        else if (item.kind == ffpa_pkg::KIND_CLEAR)
        begin
            format_pools();
            live_blocks.delete();
        end
        return r;
    endfunction

    // Receiver: stalls on its own pattern, checks each item it takes.
    int unsigned stall_phase;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item %p", rsp);
                end
                else
                begin
                    if (rsp !== pending_rsp[0])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p, got %p",
                                     pending_rsp[0], rsp);
                    end
                    void'(pending_rsp.pop_front());
                end
            end
            stall_phase <= stall_phase + 1;
            // Ready, then stalled, then random ready, in a repeating pattern.
            if (stall_phase % 97 < 40)
                rsp_ready <= 1'b1;
            else if (stall_phase % 97 < 46)
                rsp_ready <= 1'b0;
            else
                rsp_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Watchdog on cycles in which no item moves on either channel.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Directed stimulus. A typed flag of 1 means the expected result is
    // typed in; it must also match what the predictor produces.
    typedef struct {
        ffpa_pkg::req_t item;
        bit             typed;
        ffpa_pkg::rsp_t want;
    } directed_row_t;

    directed_row_t directed_rows[$];

    function automatic ffpa_pkg::req_t make_req(logic [ffpa_pkg::KIND_W-1:0] k,
                                                int unsigned bytes, int unsigned addr);
        ffpa_pkg::req_t r;
        r.kind = k;
        r.request_bytes = bytes[ffpa_pkg::BYTES_W-1:0];
        r.block_address = addr[ffpa_pkg::ADDR_W-1:0];
        return r;
    endfunction

    function automatic ffpa_pkg::rsp_t make_rsp(logic [ffpa_pkg::STATUS_W-1:0] s,
                                                int unsigned a, int unsigned u);
        ffpa_pkg::rsp_t r;
        r.status = s;
        r.granted_address = a[ffpa_pkg::ADDR_W-1:0];
        r.granted_units = u[ffpa_pkg::UNITS_W-1:0];
        return r;
    endfunction

    function automatic void add_row(ffpa_pkg::req_t item, bit typed, ffpa_pkg::rsp_t want);
        directed_row_t row;
        row.item = item;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    // Sends one item, holding valid until it is taken. Bursts keep valid high
    // from item to item; only a gap between bursts or a drain lowers it.
    int burst_left;
    task automatic send_item(ffpa_pkg::req_t item);
        ffpa_pkg::rsp_t predicted;
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted = predict_allocator(item);
        pending_rsp.push_back(predicted);
        burst_left--;
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    function automatic ffpa_pkg::req_t random_item();
        int unsigned pick;
        int unsigned idx;
        int unsigned bytes;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            // Mostly small requests so the pools fill and fragment.
            if ($urandom_range(0, 9) == 0)
                bytes = $urandom_range(0, 4095);
            else
                bytes = $urandom_range(0, 300);
            return make_req(ffpa_pkg::KIND_ALLOC, bytes, $urandom_range(0, 1023));
        end
        else if (pick < 85 && live_blocks.size() != 0)
        begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            return make_req(ffpa_pkg::KIND_FREE, $urandom_range(0, 4095), live_blocks[idx]);
        end
        else if (pick < 95)
            return make_req(ffpa_pkg::KIND_FREE, $urandom_range(0, 4095),
                            $urandom_range(0, 1023));
        else if (pick < 98)
            return make_req(ffpa_pkg::KIND_CLEAR, $urandom_range(0, 4095),
                            $urandom_range(0, 1023));
        else
            return make_req(KIND_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 1023));
    endfunction

    initial
    begin
        ffpa_pkg::rsp_t predicted;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        stall_phase = 0;
        mismatches = 0;
        idle_cycles = 0;
        burst_left = 0;
        for (int g = 0; g < STORE_UNITS; g++)
        begin
            shadow_next[g] = 0;
            shadow_size[g] = 0;
        end
        format_pools();

        // Rows written right after reset have results that follow directly
        // from the fresh pools.
        add_row(make_req(ffpa_pkg::KIND_ALLOC, 0, 0), 1,
                make_rsp(ffpa_pkg::STATUS_DONE, 63, 2));
        add_row(make_req(ffpa_pkg::KIND_ALLOC, 1008, 0), 1,
                make_rsp(ffpa_pkg::STATUS_DONE, 65, 64));
        add_row(make_req(ffpa_pkg::KIND_ALLOC, 1009, 0), 1,
                make_rsp(ffpa_pkg::STATUS_OOM, 0, 0));
        add_row(make_req(ffpa_pkg::KIND_ALLOC, 4095, 1023), 1,
                make_rsp(ffpa_pkg::STATUS_OOM, 0, 0));
        add_row(make_req(ffpa_pkg::KIND_FREE, 0, 0), 1,
                make_rsp(ffpa_pkg::STATUS_BAD_ADDR, 0, 0));
        add_row(make_req(ffpa_pkg::KIND_FREE, 0, 769), 1,
                make_rsp(ffpa_pkg::STATUS_BAD_ADDR, 0, 0));
        add_row(make_req(ffpa_pkg::KIND_FREE, 4095, 1023), 1,
                make_rsp(ffpa_pkg::STATUS_BAD_ADDR, 0, 0));
        add_row(make_req(ffpa_pkg::KIND_FREE, 0, 63), 1,
                make_rsp(ffpa_pkg::STATUS_DONE, 0, 2));
        add_row(make_req(ffpa_pkg::KIND_FREE, 0, 63), 1,
                make_rsp(ffpa_pkg::STATUS_BAD_ADDR, 0, 0));
        add_row(make_req(ffpa_pkg::KIND_FREE, 0, 65), 1,
                make_rsp(ffpa_pkg::STATUS_DONE, 0, 64));
        add_row(make_req(ffpa_pkg::KIND_FREE, 0, 1), 1,
                make_rsp(ffpa_pkg::STATUS_BAD_ADDR, 0, 0));
        add_row(make_req(ffpa_pkg::KIND_FREE, 0, 5), 1,
                make_rsp(ffpa_pkg::STATUS_BAD_ADDR, 0, 0));
        add_row(make_req(KIND_UNUSED, 4095, 1023), 1,
                make_rsp(ffpa_pkg::STATUS_DONE, 0, 0));
        add_row(make_req(ffpa_pkg::KIND_ALLOC, 16, 0), 0, '0);
        add_row(make_req(ffpa_pkg::KIND_ALLOC, 17, 0), 0, '0);
        add_row(make_req(ffpa_pkg::KIND_ALLOC, 200, 0), 0, '0);
        add_row(make_req(ffpa_pkg::KIND_FREE, 0, 60), 0, '0);
        add_row(make_req(ffpa_pkg::KIND_FREE, 0, 58), 0, '0);
        add_row(make_req(ffpa_pkg::KIND_ALLOC, 2048, 0), 0, '0);
        add_row(make_req(ffpa_pkg::KIND_CLEAR, 0, 0), 1,
                make_rsp(ffpa_pkg::STATUS_DONE, 0, 0));
        add_row(make_req(ffpa_pkg::KIND_ALLOC, 4095, 0), 1,
                make_rsp(ffpa_pkg::STATUS_OOM, 0, 0));
        add_row(make_req(ffpa_pkg::KIND_ALLOC, 2730, 682), 1,
                make_rsp(ffpa_pkg::STATUS_OOM, 0, 0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].item);
            predicted = pending_rsp[pending_rsp.size() - 1];
            if (directed_rows[i].typed && predicted !== directed_rows[i].want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("row %0d: table says %p, predictor says %p",
                             i, directed_rows[i].want, predicted);
            end
        end

        // The sender holds off until the block has answered everything.
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            send_item(random_item());
            if (n == RANDOM_ITEMS / 2)
                drain_results();
        end

        drain_results();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
